@@ design/plhb_pkg.sv @@
// Shared types and constants for the peer link binding and heartbeat block.
// Used by plhb_step, plhb_outq and the top level; no dependencies.
package plhb_pkg;

  localparam int MAX_RES = 3;
  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = 3;

  localparam logic [15:0] MAX_PAYLOAD = 16'd230;
  localparam logic [1:0]  MISS_LIMIT  = 2'd3;
  localparam logic [1:0]  MISS_SAT    = 2'd3;
  localparam logic [47:0] BCAST_ADDR  = 48'hFFFF_FFFF_FFFF;

  // Item kinds.
  localparam logic OP_TICK = 1'b0;

  // Message types.
  localparam logic [2:0] MSG_CONNECT   = 3'd1;
  localparam logic [2:0] MSG_ACK       = 3'd3;
  localparam logic [2:0] MSG_HEARTBEAT = 3'd4;
  localparam logic [2:0] MSG_DATA      = 3'd5;

  // Result actions.
  localparam logic [2:0] ACT_ADVERTISE = 3'd0;
  localparam logic [2:0] ACT_HANDSHAKE = 3'd1;
  localparam logic [2:0] ACT_HB_REQ    = 3'd2;
  localparam logic [2:0] ACT_DELIVER   = 3'd3;
  localparam logic [2:0] ACT_BOUND     = 3'd4;
  localparam logic [2:0] ACT_LOST      = 3'd5;

  // Register indexes (byte address is 8 times the index).
  localparam logic [1:0] REG_OWN_ADDR = 2'd0;
  localparam logic [1:0] REG_ADV_INT  = 2'd1;
  localparam logic [1:0] REG_CHK_INT  = 2'd2;
  localparam logic [1:0] REG_RX_TMO   = 2'd3;

  typedef struct packed {
    logic [47:0] own_address;
    logic [31:0] advertise_interval;
    logic [31:0] check_interval;
    logic [31:0] receive_timeout;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [31:0] now_ms;
    logic [47:0] sender_address;
    logic        frame_ok;
    logic [2:0]  msg_type;
    logic [47:0] from_address;
    logic [47:0] to_address;
    logic [15:0] payload_length;
  } item_t;

  typedef struct packed {
    logic        advertising;
    logic        running;
    logic [47:0] bound_address;
    logic [47:0] server_address;
    logic [31:0] last_advertise_time;
    logic [31:0] last_receive_time;
    logic [31:0] last_check_time;
    logic [1:0]  missed_heartbeats;
  } state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] dest_address;
    logic [7:0]  data_length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic room;
    logic valid;
  } q_stat_t;

endpackage

@@ design/plhb_step.sv @@
// Next-state and result logic for one item of the peer link block.
// Purely combinational; depends on plhb_pkg.
module plhb_step (
  input  plhb_pkg::cfg_t                        cfg,
  input  plhb_pkg::state_t                      st,
  input  plhb_pkg::item_t                       item,
  output plhb_pkg::state_t                      st_nxt,
  output plhb_pkg::result_t [plhb_pkg::MAX_RES-1:0] res,
  output logic [1:0]                            res_cnt
);
  import plhb_pkg::*;

  logic [31:0] adv_el;
  logic [31:0] chk_el;
  logic [31:0] rcv_el;
  logic [1:0]  miss_inc;

  assign adv_el   = item.now_ms - st.last_advertise_time;
  assign chk_el   = item.now_ms - st.last_check_time;
  // An advertising tick refreshes the receive time before the timeout check.
  assign rcv_el   = item.now_ms - (st.advertising ? item.now_ms : st.last_receive_time);
  assign miss_inc = (st.missed_heartbeats == MISS_SAT) ? MISS_SAT
                                                       : st.missed_heartbeats + 2'd1;

  always_comb begin
    logic [1:0] n;
    n      = 2'd0;
    st_nxt = st;
    res    = '0;
    if (item.op == OP_TICK) begin
      if (st.advertising) begin
        st_nxt.last_receive_time = item.now_ms;
        if (adv_el > cfg.advertise_interval) begin
          st_nxt.last_advertise_time = item.now_ms;
          res[n].action       = ACT_ADVERTISE;
          res[n].dest_address = BCAST_ADDR;
          n = n + 2'd1;
        end
      end
      if (st.running && chk_el > cfg.check_interval) begin
        st_nxt.last_check_time = item.now_ms;
        if (rcv_el > cfg.receive_timeout) begin
          res[n].action       = ACT_HB_REQ;
          res[n].dest_address = st.server_address;
          n = n + 2'd1;
          st_nxt.missed_heartbeats = miss_inc;
          if (miss_inc >= MISS_LIMIT) begin
            res[n].action              = ACT_LOST;
            res[n].dest_address        = st.server_address;
            n = n + 2'd1;
            st_nxt.server_address      = '0;
            st_nxt.bound_address       = '0;
            st_nxt.running             = 1'b0;
            st_nxt.advertising         = 1'b1;
            st_nxt.last_advertise_time = '0;
          end
        end
      end
    end else if (item.sender_address != cfg.own_address && item.frame_ok) begin
      st_nxt.last_receive_time = item.now_ms;
      // Anything past connect must come from the bound peer.
      if (!(item.msg_type > MSG_CONNECT && item.from_address != st.bound_address)) begin
        case (item.msg_type)
          MSG_CONNECT: begin
            if (item.to_address == cfg.own_address) begin
              st_nxt.bound_address = item.from_address;
              st_nxt.advertising   = 1'b0;
              res[n].action        = ACT_HANDSHAKE;
              res[n].dest_address  = item.sender_address;
              n = n + 2'd1;
            end
          end
          MSG_ACK: begin
            st_nxt.running        = 1'b1;
            st_nxt.server_address = item.from_address;
            st_nxt.bound_address  = item.from_address;
            res[n].action         = ACT_BOUND;
            res[n].dest_address   = item.from_address;
            n = n + 2'd1;
          end
          MSG_HEARTBEAT: begin
            st_nxt.missed_heartbeats = 2'd0;
          end
          MSG_DATA: begin
            if (item.payload_length != 16'd0 && item.payload_length <= MAX_PAYLOAD) begin
              res[n].action       = ACT_DELIVER;
              res[n].dest_address = item.from_address;
              res[n].data_length  = item.payload_length[7:0];
              n = n + 2'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end
    res_cnt = n;
  end

endmodule

@@ design/plhb_outq.sv @@
// Result queue: takes up to three results per cycle, hands out one per transfer.
// Depends on plhb_pkg.
module plhb_outq (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [1:0]                            push_cnt,
  input  plhb_pkg::result_t [plhb_pkg::MAX_RES-1:0] push_res,
  input  logic                                  pop,
  output plhb_pkg::result_t                     head,
  output plhb_pkg::q_stat_t                     stat
);
  import plhb_pkg::*;

  result_t         q_r [Q_DEPTH];
  result_t         push_tag [MAX_RES];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            do_pop;

  assign do_pop     = pop && (count_r != '0);
  assign wr_ptr_nxt = wr_ptr_r + Q_AW'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + Q_AW'(do_pop);
  assign count_nxt  = count_r + (Q_AW + 1)'(push_cnt) - (Q_AW + 1)'(do_pop);

  assign head       = q_r[rd_ptr_r];
  assign stat.valid = (count_r != '0);
  assign stat.room  = (count_r <= (Q_AW + 1)'(Q_DEPTH - MAX_RES));

  // The final result of an item carries the last flag.
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      push_tag[i]      = push_res[i];
      push_tag[i].last = (2'(i) == push_cnt - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_cnt) begin
        q_r[wr_ptr_r + Q_AW'(i)] <= push_tag[i];
      end
    end
  end

endmodule

@@ design/peer_link_binding_heartbeat_fsm.sv @@
// Peer link client: binding, advertising and heartbeat supervision.
// Path: an accepted item is held in the input register and evaluated from it once the
// queue has room; its results are then written into the output queue, which offers them.
// Throughput: one item per cycle while the queue has room; each result takes one output
// transfer; the queue (eight entries, up to three per item) sets the rate of busy streams.
// Reset: synchronous, active low; clears state and registers to reset values, empties queue.
module peer_link_binding_heartbeat_fsm (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata from bit 0: now_ms[32], sender_address[48], frame_ok[1], msg_type[3],
  // from_address[48], to_address[48], payload_length[16], zero pad[4]
  input  logic [199:0] in_tdata,
  // in_tuser: op[1]
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata from bit 0: dest_address[48], data_length[8]
  output logic [55:0]  out_tdata,
  // out_tuser: action[3]
  output logic [2:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  import plhb_pkg::*;

  cfg_t      cfg_r;
  state_t    st_r, st_nxt;
  item_t     s1_item_r;
  logic      s1_valid_r;
  logic      s1_adv;
  logic      in_xfer;
  result_t [MAX_RES-1:0] step_res;
  logic [1:0] step_cnt;
  logic [1:0] push_cnt;
  logic      lost_seen;
  result_t   head;
  q_stat_t   q_stat;
  item_t     in_item;

  assign in_item.op             = in_tuser[0];
  assign in_item.now_ms         = in_tdata[31:0];
  assign in_item.sender_address = in_tdata[79:32];
  assign in_item.frame_ok       = in_tdata[80];
  assign in_item.msg_type       = in_tdata[83:81];
  assign in_item.from_address   = in_tdata[131:84];
  assign in_item.to_address     = in_tdata[179:132];
  assign in_item.payload_length = in_tdata[195:180];

  // Configuration port.
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[4:3])
      REG_OWN_ADDR: cfg_prdata = {16'd0, cfg_r.own_address};
      REG_ADV_INT:  cfg_prdata = {32'd0, cfg_r.advertise_interval};
      REG_CHK_INT:  cfg_prdata = {32'd0, cfg_r.check_interval};
      REG_RX_TMO:   cfg_prdata = {32'd0, cfg_r.receive_timeout};
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address        <= '0;
      cfg_r.advertise_interval <= 32'd1000;
      cfg_r.check_interval     <= 32'd1000;
      cfg_r.receive_timeout    <= 32'd5000;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[4:3])
        REG_OWN_ADDR: cfg_r.own_address        <= cfg_pwdata[47:0];
        REG_ADV_INT:  cfg_r.advertise_interval <= cfg_pwdata[31:0];
        REG_CHK_INT:  cfg_r.check_interval     <= cfg_pwdata[31:0];
        REG_RX_TMO:   cfg_r.receive_timeout    <= cfg_pwdata[31:0];
        default: begin
        end
      endcase
    end
  end

  // The held item is evaluated once the queue can take its worst case of results.
  assign s1_adv    = s1_valid_r && q_stat.room;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
  end

  plhb_step u_step (
    .cfg     (cfg_r),
    .st      (st_r),
    .item    (s1_item_r),
    .st_nxt  (st_nxt),
    .res     (step_res),
    .res_cnt (step_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.advertising         <= 1'b1;
      st_r.running             <= 1'b0;
      st_r.bound_address       <= '0;
      st_r.server_address      <= '0;
      st_r.last_advertise_time <= '0;
      st_r.last_receive_time   <= '0;
      st_r.last_check_time     <= '0;
      st_r.missed_heartbeats   <= '0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  assign push_cnt = s1_adv ? step_cnt : 2'd0;

  plhb_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .push_res (step_res),
    .pop      (out_tready),
    .head     (head),
    .stat     (q_stat)
  );

  assign out_tvalid = q_stat.valid;
  assign out_tdata  = {head.data_length, head.dest_address};
  assign out_tuser  = head.action;
  assign out_tlast  = head.last;

  assign lost_seen = (step_cnt != 2'd0) && (step_res[step_cnt - 2'd1].action == ACT_LOST);

  // A stalled item stays put until the queue has room.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_item_r))
    else $error("held item changed while stalled");

  // Dropping the link returns to advertising with the link down.
  a_lost_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && lost_seen |=> st_r.advertising && !st_r.running)
    else $error("link lost did not restore advertising");

  // An idle node (neither advertising nor running) produces nothing on a tick.
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_item_r.op == OP_TICK && !st_r.running && !st_r.advertising
      |-> step_cnt == 2'd0)
    else $error("tick produced results while idle");

  // Results enter the queue only when its room was checked.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |-> q_stat.room && s1_valid_r)
    else $error("results pushed without room");

endmodule

@@ tb/sv/peer_link_binding_heartbeat_fsm_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for peer_link_binding_heartbeat_fsm: a directed table, then random
// traffic over several register settings, results checked against table or in-bench predictor.
// Depends on plhb_pkg and the block's RTL.
module peer_link_binding_heartbeat_fsm_tb;
  import plhb_pkg::*;

  localparam logic       OP_MSG        = 1'b1;
  localparam logic [2:0] MSG_ADVERTISE = 3'd0;
  localparam logic [2:0] MSG_HANDSHAKE = 3'd2;
  localparam logic [2:0] MSG_RESERVED  = 3'd7;
  localparam int         QUIET_LIMIT   = 5000;
  localparam int         SETTLE_CYCLES = 4;

  localparam logic [47:0] SRV_ADDR   = 48'hA5A5_5A5A_0F0F;
  localparam logic [47:0] RELAY_ADDR = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] OTHER_ADDR = 48'h0000_0000_0042;

  typedef struct {
    item_t   it;
    bit      typed;
    bit      has_result;
    result_t want;
  } row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // in_tdata from bit 0: now_ms, sender_address, frame_ok, msg_type, from_address,
  // to_address, payload_length, zero pad
  logic [199:0] in_tdata;
  // in_tuser: op
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  // out_tdata from bit 0: dest_address, data_length
  logic [55:0]  out_tdata;
  // out_tuser: action
  logic [2:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [63:0]  cfg_pwdata;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  cfg_t        link_cfg;
  state_t      link_st;
  result_t     step_results[$];
  result_t     expected_actions[$];
  row_t        directed_rows[$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  bit          gaps_on = 1'b1;
  logic [31:0] sim_now = '0;
  int unsigned step_max = 1;
  logic [47:0] peer_srv = '0;

  peer_link_binding_heartbeat_fsm uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [47:0] rand48();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[47:0];
  endfunction

  function automatic logic [31:0] elapsed(logic [31:0] now, logic [31:0] since);
    return now - since;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  function void reset_predictor();
    link_cfg = '0;
    link_cfg.advertise_interval = 32'd1000;
    link_cfg.check_interval = 32'd1000;
    link_cfg.receive_timeout = 32'd5000;
    link_st = '0;
    link_st.advertising = 1'b1;
  endfunction

  function void emit_action(logic [2:0] act, logic [47:0] dest, logic [7:0] len);
    result_t r;
    r.action = act;
    r.dest_address = dest;
    r.data_length = len;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function void link_tick(logic [31:0] now);
    if (link_st.advertising) begin
      // Every tick while advertising counts as reception.
      link_st.last_receive_time = now;
      if (elapsed(now, link_st.last_advertise_time) > link_cfg.advertise_interval) begin
        link_st.last_advertise_time = now;
        emit_action(ACT_ADVERTISE, BCAST_ADDR, 8'd0);
      end
    end
    if (!link_st.running) return;
    if (elapsed(now, link_st.last_check_time) <= link_cfg.check_interval) return;
    link_st.last_check_time = now;
    if (elapsed(now, link_st.last_receive_time) <= link_cfg.receive_timeout) return;
    emit_action(ACT_HB_REQ, link_st.server_address, 8'd0);
    if (link_st.missed_heartbeats < MISS_SAT)
      link_st.missed_heartbeats = link_st.missed_heartbeats + 2'd1;
    if (link_st.missed_heartbeats < MISS_LIMIT) return;
    // The miss count survives the drop, so the next timeout drops at once.
    emit_action(ACT_LOST, link_st.server_address, 8'd0);
    link_st.server_address = '0;
    link_st.bound_address = '0;
    link_st.running = 1'b0;
    link_st.advertising = 1'b1;
    link_st.last_advertise_time = '0;
  endfunction

  function void link_message(item_t it);
    if (it.sender_address == link_cfg.own_address) return;
    if (!it.frame_ok) return;
    link_st.last_receive_time = it.now_ms;
    if (it.msg_type > MSG_CONNECT && it.from_address != link_st.bound_address) return;
    case (it.msg_type)
      MSG_CONNECT: begin
        if (it.to_address != link_cfg.own_address) return;
        link_st.bound_address = it.from_address;
        emit_action(ACT_HANDSHAKE, it.sender_address, 8'd0);
        link_st.advertising = 1'b0;
      end
      MSG_ACK: begin
        link_st.running = 1'b1;
        link_st.server_address = it.from_address;
        link_st.bound_address = it.from_address;
        emit_action(ACT_BOUND, it.from_address, 8'd0);
      end
      MSG_HEARTBEAT: begin
        link_st.missed_heartbeats = '0;
      end
      MSG_DATA: begin
        if (it.payload_length == 16'd0 || it.payload_length > MAX_PAYLOAD) return;
        emit_action(ACT_DELIVER, it.from_address, it.payload_length[7:0]);
      end
      default: ;
    endcase
  endfunction

  function void predict_link_actions(item_t it);
    step_results.delete();
    if (it.op == OP_TICK) link_tick(it.now_ms);
    else link_message(it);
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  function automatic item_t tick_at(logic [31:0] now);
    item_t it;
    it = '0;
    it.op = OP_TICK;
    it.now_ms = now;
    return it;
  endfunction

  function automatic item_t msg_at(logic [31:0] now, logic [47:0] sender, logic ok,
                                   logic [2:0] mtype, logic [47:0] from, logic [47:0] to,
                                   logic [15:0] len);
    item_t it;
    it.op = OP_MSG;
    it.now_ms = now;
    it.sender_address = sender;
    it.frame_ok = ok;
    it.msg_type = mtype;
    it.from_address = from;
    it.to_address = to;
    it.payload_length = len;
    return it;
  endfunction

  function void expect_none(item_t it);
    row_t r;
    r.it = it;
    r.typed = 1'b1;
    r.has_result = 1'b0;
    r.want = '0;
    directed_rows.push_back(r);
  endfunction

  function void expect_one(item_t it, logic [2:0] act, logic [47:0] dest, logic [7:0] len);
    row_t r;
    r.it = it;
    r.typed = 1'b1;
    r.has_result = 1'b1;
    r.want.action = act;
    r.want.dest_address = dest;
    r.want.data_length = len;
    r.want.last = 1'b1;
    directed_rows.push_back(r);
  endfunction

  function void predicted(item_t it);
    row_t r;
    r.it = it;
    r.typed = 1'b0;
    r.has_result = 1'b0;
    r.want = '0;
    directed_rows.push_back(r);
  endfunction

  // Mostly well-formed traffic toward the peer the predictor is bound to, plus noise.
  function automatic item_t random_link_item();
    item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.op = OP_MSG;
    it.sender_address = rand48();
    it.frame_ok = 1'b1;
    it.msg_type = MSG_DATA;
    it.from_address = rand48();
    it.to_address = rand48();
    it.payload_length = 16'($urandom_range(0, 65535));
    if (pick < 35) begin
      sim_now = sim_now + $urandom_range(0, step_max);
      it.op = OP_TICK;
      it.msg_type = 3'($urandom_range(0, 7));
      it.frame_ok = 1'($urandom_range(0, 1));
    end else begin
      sim_now = sim_now + $urandom_range(0, step_max / 4);
      if (pick < 45) begin
        it.msg_type = MSG_CONNECT;
        if ($urandom_range(0, 3) != 0) it.from_address = peer_srv;
        it.to_address = link_cfg.own_address;
      end else if (pick < 55) begin
        it.msg_type = MSG_ACK;
        it.from_address = link_st.bound_address;
      end else if (pick < 65) begin
        it.msg_type = MSG_HEARTBEAT;
        it.from_address = link_st.bound_address;
      end else if (pick < 80) begin
        it.msg_type = MSG_DATA;
        it.from_address = link_st.bound_address;
        if ($urandom_range(0, 4) != 0) it.payload_length = 16'($urandom_range(1, 230));
      end else begin
        it.op = 1'($urandom_range(0, 1));
        it.frame_ok = 1'($urandom_range(0, 1));
        it.msg_type = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 2) == 0) it.sender_address = link_cfg.own_address;
        if ($urandom_range(0, 1) == 0) it.from_address = link_st.bound_address;
        if ($urandom_range(0, 1) == 0) it.to_address = link_cfg.own_address;
        if ($urandom_range(0, 3) == 0) sim_now = $urandom;
      end
    end
    it.now_ms = sim_now;
    return it;
  endfunction

  task automatic offer_item(item_t it, bit typed, bit has_result, result_t want);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 17)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = it.op;
    in_tdata = {4'b0, it.payload_length, it.to_address, it.from_address, it.msg_type,
                it.frame_ok, it.sender_address, it.now_ms};
    do @(posedge clk); while (!in_tready);
    predict_link_actions(it);
    if (!typed) begin
      foreach (step_results[i]) expected_actions.push_back(step_results[i]);
    end else if (has_result) begin
      expected_actions.push_back(want);
    end
  endtask

  // Results pass the input register and the queue; a resultless item may still be in flight.
  task automatic drain_link();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 3'b000};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_OWN_ADDR: link_cfg.own_address = value[47:0];
      REG_ADV_INT:  link_cfg.advertise_interval = value[31:0];
      REG_CHK_INT:  link_cfg.check_interval = value[31:0];
      REG_RX_TMO:   link_cfg.receive_timeout = value[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic configure(logic [47:0] own, logic [31:0] adv, logic [31:0] chk,
                           logic [31:0] tmo);
    write_reg(REG_OWN_ADDR, {16'd0, own});
    write_reg(REG_ADV_INT, {32'd0, adv});
    write_reg(REG_CHK_INT, {32'd0, chk});
    write_reg(REG_RX_TMO, {32'd0, tmo});
  endtask

  task automatic run_random(int count);
    repeat (count) offer_item(random_link_item(), 1'b0, 1'b0, '0);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) hold_left--;
    else if (gaps_on && $urandom_range(0, 5) == 0) hold_left = $urandom_range(1, 18);
    out_tready = (hold_left == 0);
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_actions.size() == 0) begin
        report_mismatch("unexpected result, action", 64'(out_tuser), 64'(0));
      end else begin
        want = expected_actions.pop_front();
        if (out_tuser != want.action)
          report_mismatch("action", 64'(out_tuser), 64'(want.action));
        if (out_tdata[47:0] != want.dest_address)
          report_mismatch("dest_address", 64'(out_tdata[47:0]), 64'(want.dest_address));
        if (out_tdata[55:48] != want.data_length)
          report_mismatch("data_length", 64'(out_tdata[55:48]), 64'(want.data_length));
        if (out_tlast != want.last)
          report_mismatch("last", 64'(out_tlast), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    reset_predictor();

    // Directed part runs on the reset register values, so our own address is zero.
    expect_none(tick_at(32'd0));
    expect_one(tick_at(32'd1001), ACT_ADVERTISE, BCAST_ADDR, 8'd0);
    expect_one(tick_at(32'hFFFF_FFFF), ACT_ADVERTISE, BCAST_ADDR, 8'd0);
    expect_none(tick_at(32'd500));  // elapsed time wraps to 501
    expect_none(msg_at(32'd1000, 48'd0, 1'b1, MSG_CONNECT, SRV_ADDR, 48'd0, 16'd0));
    expect_none(msg_at(32'd1000, RELAY_ADDR, 1'b0, MSG_CONNECT, SRV_ADDR, 48'd0, 16'd0));
    expect_none(msg_at(32'd1000, RELAY_ADDR, 1'b1, MSG_CONNECT, SRV_ADDR, OTHER_ADDR, 16'd0));
    expect_none(msg_at(32'd1000, RELAY_ADDR, 1'b1, MSG_ADVERTISE, OTHER_ADDR, 48'd0, 16'd0));
    expect_none(msg_at(32'd1000, RELAY_ADDR, 1'b1, MSG_DATA, OTHER_ADDR, 48'd0, 16'd10));
    expect_one(msg_at(32'd1000, RELAY_ADDR, 1'b1, MSG_CONNECT, SRV_ADDR, 48'd0, 16'd0),
               ACT_HANDSHAKE, RELAY_ADDR, 8'd0);
    expect_one(msg_at(32'd1000, RELAY_ADDR, 1'b1, MSG_ACK, SRV_ADDR, 48'd0, 16'd0),
               ACT_BOUND, SRV_ADDR, 8'd0);
    expect_none(msg_at(32'd1000, RELAY_ADDR, 1'b1, MSG_DATA, SRV_ADDR, 48'd0, 16'd0));
    expect_one(msg_at(32'd1000, RELAY_ADDR, 1'b1, MSG_DATA, SRV_ADDR, 48'd0, 16'd230),
               ACT_DELIVER, SRV_ADDR, 8'd230);
    expect_none(msg_at(32'd1000, RELAY_ADDR, 1'b1, MSG_DATA, SRV_ADDR, 48'd0, 16'd231));
    expect_none(msg_at(32'd1000, RELAY_ADDR, 1'b1, MSG_DATA, SRV_ADDR, 48'd0, 16'hFFFF));
    expect_one(msg_at(32'd1000, RELAY_ADDR, 1'b1, MSG_DATA, SRV_ADDR, 48'd0, 16'd1),
               ACT_DELIVER, SRV_ADDR, 8'd1);
    expect_none(msg_at(32'd1000, RELAY_ADDR, 1'b1, MSG_HANDSHAKE, SRV_ADDR, 48'd0, 16'd0));
    expect_none(msg_at(32'd1000, RELAY_ADDR, 1'b1, MSG_RESERVED, SRV_ADDR, 48'd0, 16'd0));
    predicted(tick_at(32'd2001));
    predicted(tick_at(32'd7002));
    expect_none(msg_at(32'd7100, RELAY_ADDR, 1'b1, MSG_HEARTBEAT, SRV_ADDR, 48'd0, 16'd0));
    // Three missed checks in a row drop the link.
    predicted(tick_at(32'd13000));
    predicted(tick_at(32'd14001));
    predicted(tick_at(32'd15002));
    // An ack while unbound leaves the block both advertising and running.
    expect_one(msg_at(32'd15100, RELAY_ADDR, 1'b1, MSG_ACK, 48'd0, 48'd0, 16'd0),
               ACT_BOUND, 48'd0, 8'd0);
    predicted(tick_at(32'd16200));
    expect_one(msg_at(32'd16300, RELAY_ADDR, 1'b1, MSG_CONNECT, SRV_ADDR, 48'd0, 16'd0),
               ACT_HANDSHAKE, RELAY_ADDR, 8'd0);
    predicted(tick_at(32'd22000));  // kept miss count drops the link on the first timeout

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      offer_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].has_result,
                 directed_rows[i].want);

    // Zero intervals: every tick that moves time forward fires.
    drain_link();
    configure(48'hFFFF_FFFF_FFFF, 32'd0, 32'd0, 32'd0);
    peer_srv = rand48();
    sim_now = $urandom;
    step_max = 3;
    run_random(33);

    // Maximum intervals: ticks can never fire.
    drain_link();
    configure(rand48(), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    peer_srv = rand48();
    step_max = 200000;
    run_random(33);

    drain_link();
    configure(rand48(), $urandom_range(1, 300), $urandom_range(1, 300),
              $urandom_range(100, 1500));
    peer_srv = rand48();
    step_max = 700;
    run_random(33);

    // Closing stretch runs at full rate on both sides.
    drain_link();
    gaps_on = 1'b0;
    configure(48'd0, 32'd50, 32'd20, 32'd100);
    peer_srv = rand48();
    step_max = 80;
    run_random(33);

    drain_link();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
